/* sv/anf_pkg.sv */
// Shared types and constants for the advertising-data local-name filter.
package anf_pkg;

  localparam int NAME_MAX = 16;
  localparam int TLEN_W   = 5;
  localparam int OFF_W    = 5;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;

  localparam logic [2:0] REG_TLEN     = 3'd0;
  localparam logic [2:0] REG_NAME_LO  = 3'd1;
  localparam logic [2:0] REG_NAME_HI  = 3'd2;
  localparam logic [2:0] REG_CPL_TYPE = 3'd3;
  localparam logic [2:0] REG_SHT_TYPE = 3'd4;

  localparam logic [1:0] SRC_NONE     = 2'd0;
  localparam logic [1:0] SRC_COMPLETE = 2'd1;
  localparam logic [1:0] SRC_SHORT    = 2'd2;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_COMPLETE,
    KIND_SHORT
  } kind_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_payload;
  } anf_in_t;

  typedef struct packed {
    logic       name_match;
    logic [1:0] name_source;
    logic       malformed;
  } anf_out_t;

  typedef struct packed {
    logic [TLEN_W-1:0] name_len;
    logic [63:0]       name_lo;
    logic [63:0]       name_hi;
    logic [7:0]        cpl_type;
    logic [7:0]        sht_type;
  } anf_cfg_t;

  typedef struct packed {
    logic     load;
    anf_out_t data;
  } anf_res_t;

endpackage

/* sv/anf_cfg.sv */
// APB register file holding the target name and name type codes.
module anf_cfg import anf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output anf_cfg_t          cfg
);

  anf_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.name_len <= '0;
      cfg_r.name_lo  <= '0;
      cfg_r.name_hi  <= '0;
      cfg_r.cpl_type <= 8'd9;
      cfg_r.sht_type <= 8'd8;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TLEN:     cfg_r.name_len <= pwdata[TLEN_W-1:0];
        REG_NAME_LO:  cfg_r.name_lo  <= pwdata;
        REG_NAME_HI:  cfg_r.name_hi  <= pwdata;
        REG_CPL_TYPE: cfg_r.cpl_type <= pwdata[7:0];
        REG_SHT_TYPE: cfg_r.sht_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TLEN:     prdata = {{(DATA_W-TLEN_W){1'b0}}, cfg_r.name_len};
      REG_NAME_LO:  prdata = cfg_r.name_lo;
      REG_NAME_HI:  prdata = cfg_r.name_hi;
      REG_CPL_TYPE: prdata = {{(DATA_W-8){1'b0}}, cfg_r.cpl_type};
      REG_SHT_TYPE: prdata = {{(DATA_W-8){1'b0}}, cfg_r.sht_type};
      default:      prdata = '0;
    endcase
  end

endmodule

/* sv/anf_parse.sv */
// Input register and per-byte length-type-data parser with name compare.
module anf_parse import anf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  anf_in_t  in_data,
  input  anf_cfg_t cfg,
  input  logic     slot_free,
  output anf_res_t res
);

  logic             in_vld_r;
  anf_in_t          in_item_r;
  logic             go;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       left_r, left_nxt;
  kind_t            kind_r, kind_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             run_r, run_nxt;
  logic             cseen_r, cseen_nxt;
  logic             cmat_r, cmat_nxt;
  logic             sseen_r, sseen_nxt;
  logic             smat_r, smat_nxt;
  logic             stop_r, stop_nxt;

  logic [15:0][7:0]  tgt;
  logic [TLEN_W-1:0] tlen;
  logic [7:0]        b;
  logic              end_cs, end_cm, end_ss, end_sm;

  assign go       = in_vld_r && (!in_item_r.end_of_payload || slot_free);
  assign in_stall = in_vld_r && !go;
  assign tgt      = {cfg.name_hi, cfg.name_lo};
  assign tlen     = (cfg.name_len > TLEN_W'(NAME_MAX)) ? TLEN_W'(NAME_MAX) : cfg.name_len;
  assign b        = in_item_r.payload_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // next parse state for the byte in the input register
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    kind_nxt  = kind_r;
    off_nxt   = off_r;
    run_nxt   = run_r;
    cseen_nxt = cseen_r;
    cmat_nxt  = cmat_r;
    sseen_nxt = sseen_r;
    smat_nxt  = smat_r;
    stop_nxt  = stop_r;
    if (!stop_r) begin
      unique case (phase_r)
        PH_TYPE: begin
          left_nxt = left_r - 8'd1;
          if (b == cfg.cpl_type && !cseen_r) begin
            kind_nxt = KIND_COMPLETE;
          end else if (b == cfg.sht_type && !sseen_r) begin
            kind_nxt = KIND_SHORT;
          end else begin
            kind_nxt = KIND_NONE;
          end
          off_nxt = '0;
          run_nxt = 1'b1;
          if (left_nxt == 8'd0) begin
            if (kind_nxt == KIND_COMPLETE) begin
              cseen_nxt = 1'b1;
              cmat_nxt  = 1'b1;
            end else if (kind_nxt == KIND_SHORT) begin
              sseen_nxt = 1'b1;
              smat_nxt  = 1'b1;
            end
            kind_nxt  = KIND_NONE;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (kind_r != KIND_NONE) begin
            if (off_r >= tlen || b != tgt[off_r[3:0]]) begin
              run_nxt = 1'b0;
            end
            if (off_r < OFF_W'(NAME_MAX)) begin
              off_nxt = off_r + OFF_W'(1);
            end
          end
          left_nxt = left_r - 8'd1;
          if (left_nxt == 8'd0) begin
            if (kind_r == KIND_COMPLETE) begin
              cseen_nxt = 1'b1;
              cmat_nxt  = run_nxt;
            end else if (kind_r == KIND_SHORT) begin
              sseen_nxt = 1'b1;
              smat_nxt  = run_nxt;
            end
            kind_nxt  = KIND_NONE;
            phase_nxt = PH_LEN;
          end
        end
        default: begin
          if (b == 8'd0) begin
            stop_nxt = 1'b1;
          end else begin
            left_nxt  = b;
            phase_nxt = PH_TYPE;
          end
        end
      endcase
    end
  end

  // result for the last byte of a payload
  always_comb begin
    end_cs = cseen_nxt;
    end_cm = cmat_nxt;
    end_ss = sseen_nxt;
    end_sm = smat_nxt;
    if (!stop_nxt && phase_nxt == PH_DATA) begin
      if (kind_nxt == KIND_COMPLETE) begin
        end_cs = 1'b1;
        end_cm = 1'b0;
      end else if (kind_nxt == KIND_SHORT) begin
        end_ss = 1'b1;
        end_sm = 1'b0;
      end
    end
    res.load           = go && in_item_r.end_of_payload;
    res.data.malformed = !stop_nxt && phase_nxt != PH_LEN;
    if (end_cs) begin
      res.data.name_source = SRC_COMPLETE;
      res.data.name_match  = end_cm;
    end else if (end_ss) begin
      res.data.name_source = SRC_SHORT;
      res.data.name_match  = end_sm;
    end else begin
      res.data.name_source = SRC_NONE;
      res.data.name_match  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && in_item_r.end_of_payload)) begin
      phase_r <= PH_LEN;
      left_r  <= '0;
      kind_r  <= KIND_NONE;
      off_r   <= '0;
      run_r   <= 1'b1;
      cseen_r <= 1'b0;
      cmat_r  <= 1'b0;
      sseen_r <= 1'b0;
      smat_r  <= 1'b0;
      stop_r  <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      kind_r  <= kind_nxt;
      off_r   <= off_nxt;
      run_r   <= run_nxt;
      cseen_r <= cseen_nxt;
      cmat_r  <= cmat_nxt;
      sseen_r <= sseen_nxt;
      smat_r  <= smat_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

/* sv/anf_out.sv */
// Result register between the parser and the result channel.
module anf_out import anf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  anf_res_t res,
  output logic     slot_free,
  output logic     out_valid,
  input  logic     out_stall,
  output anf_out_t out_data
);

  logic     out_valid_r;
  anf_out_t out_data_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data_r <= res.data;
    end
  end

endmodule

/* sv/adv_data_name_filter_top.sv */
// Top level of the advertising-data local-name filter.
// Takes one advertising payload byte per item, one item per cycle, and gives one
// result on the item marked end_of_payload: name match, name source (complete
// name over short name) and a malformed flag. Each byte passes from an input
// register through combinational parse and compare logic, and the last byte's
// result is registered; the pipe stalls only while a finished result waits.
// Registers sit on APB at byte address 8*index, 64-bit data.
module adv_data_name_filter_top import anf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  anf_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output anf_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  anf_cfg_t cfg;
  anf_res_t res;
  logic     slot_free;

  anf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  anf_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .slot_free (slot_free),
    .res       (res)
  );

  anf_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
